// ===== design/sitda_pkg.sv =====
// Package with the shared command and status types of the decimal text converter.
package sitda_pkg;

  localparam logic [5:0] ASCII_ZERO  = 6'd48;
  localparam logic [5:0] ASCII_MINUS = 6'd45;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit_sign;
    logic emit_digit;
    logic skip;
  } cmd_t;

  typedef struct packed {
    logic bit_last;
    logic neg;
    logic digit_zero;
    logic idx_zero;
  } status_t;

endpackage

// ===== design/sitda_ctrl.sv =====
// Controller state machine that sequences conversion and character output.
module sitda_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sitda_pkg::status_t sts,
  output sitda_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CONV   = 2'd1;
  localparam logic [1:0] ST_SIGN   = 2'd2;
  localparam logic [1:0] ST_DIGITS = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       started;
  logic       started_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    started_next = started;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          started_next = 1'b0;
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.bit_last) begin
          state_next = sts.neg ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (!started && sts.digit_zero && !sts.idx_zero) begin
          cmd.skip = 1'b1;
        end else begin
          cmd.emit_digit = 1'b1;
          started_next   = 1'b1;
          if (sts.idx_zero) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
    end
  end

endmodule

// ===== design/sitda_dp.sv =====
// Datapath with the shift-and-add-3 converter, digit index and output register.
module sitda_dp #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] value,
  input  sitda_pkg::cmd_t       cmd,
  output sitda_pkg::status_t    sts,
  output logic                  strobe,
  output logic [5:0]            char_code,
  output logic                  last
);

  localparam int ND    = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
  localparam int IDX_W = $clog2(ND);
  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] mag;
  logic [ND*4-1:0]       bcd;
  logic [ND*4-1:0]       adj;
  logic                  neg;
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      bitcnt;
  logic [3:0]            digit;

  assign digit = bcd[idx*4 +: 4];

  always_comb begin
    logic [3:0] d;
    d = '0;
    for (int i = 0; i < ND; i++) begin
      d = bcd[i*4 +: 4];
      adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  assign sts.bit_last   = (bitcnt == '0);
  assign sts.neg        = neg;
  assign sts.digit_zero = (digit == 4'd0);
  assign sts.idx_zero   = (idx == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg    <= value[VALUE_BITS-1];
      mag    <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      bcd    <= '0;
      bitcnt <= CNT_W'(VALUE_BITS - 1);
      idx    <= IDX_W'(ND - 1);
    end else if (cmd.shift) begin
      bcd    <= {adj[ND*4-2:0], mag[VALUE_BITS-1]};
      mag    <= {mag[VALUE_BITS-2:0], 1'b0};
      bitcnt <= bitcnt - 1'b1;
    end else if (cmd.skip || cmd.emit_digit) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_code <= sitda_pkg::ASCII_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= sitda_pkg::ASCII_ZERO | {2'b00, digit};
      last      <= (idx == '0);
    end
  end

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII text converter.
// An item runs the shift-and-add-3 steps, one per value bit, then a minus sign if negative,
// then each digit position in turn; skipped leading zeros leave gaps between characters.
// A new item is taken only while idle, so its start comes at the earliest with the last strobe.
// Reset idles the controller and clears the strobe; the receiver cannot stall.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  strobe,
  output logic [5:0]            char_code,
  output logic                  last
);

  sitda_pkg::cmd_t    cmd;
  sitda_pkg::status_t sts;

  sitda_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sitda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("character strobe without an item in progress");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("character strobe right after the last character");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (char_code == sitda_pkg::ASCII_MINUS) |-> !last)
    else $error("minus sign flagged as last character");

endmodule
